// ===== rtl/core/string_escape_decoder_unit_defines.svh =====
// Assertion helpers for the string escape decoder
`ifndef STRING_ESCAPE_DECODER_UNIT_DEFINES_SVH
`define STRING_ESCAPE_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked after reset
`define SED_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked after reset
`define SED_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sed_pkg.sv =====
package sed_pkg;

   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam logic [7:0] LETTER_X  = 8'h78;
   localparam logic [7:0] ESC_CHAR  = 8'h1B;

   localparam logic [1:0] MODE_TEXT    = 2'd0;
   localparam logic [1:0] MODE_ESCAPE  = 2'd1;
   localparam logic [1:0] MODE_HEX     = 2'd2;
   localparam logic [1:0] MODE_HEX_ONE = 2'd3;

   localparam int unsigned MAX_RESULTS = 4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       unknown_escape;
      logic       unterminated;
      logic       last;
   } sed_result_type;

   typedef struct packed {
      logic [2:0]                           count;
      sed_result_type [MAX_RESULTS-1:0]     ent;
   } sed_burst_type;

   function automatic sed_result_type mk_result(input logic [7:0] b, input logic has,
                                                input logic unk, input logic unt,
                                                input logic lst);
      sed_result_type r;
      r.out_byte       = b;
      r.has_byte       = has;
      r.unknown_escape = unk;
      r.unterminated   = unt;
      r.last           = lst;
      return r;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] t;
      if (c <= 8'h39) begin
         t = c - 8'h30;
      end else if (c >= 8'h61) begin
         t = c - 8'h57;
      end else begin
         t = c - 8'h37;
      end
      return t[3:0];
   endfunction

   function automatic logic is_escape(input logic [7:0] c);
      return c == 8'h30 || c == 8'h61 || c == 8'h62 || c == 8'h65 || c == 8'h66 ||
             c == 8'h6E || c == 8'h72 || c == 8'h74 || c == 8'h76 || c == BACKSLASH ||
             c == 8'h27 || c == 8'h22;
   endfunction

   function automatic logic [7:0] escape_byte(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         8'h30:     v = 8'h00;
         8'h61:     v = 8'h07;
         8'h62:     v = 8'h08;
         8'h65:     v = ESC_CHAR;
         8'h66:     v = 8'h0C;
         8'h6E:     v = 8'h0A;
         8'h72:     v = 8'h0D;
         8'h74:     v = 8'h09;
         8'h76:     v = 8'h0B;
         default:   v = c;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/sed_decode.sv =====
module sed_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   kind,
   input  logic [7:0]             ch,
   output sed_pkg::sed_burst_type burst
);
   import sed_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic [7:0] held_ff, held_in;
   logic       plain_emit;
   logic [1:0] plain_mode;
   sed_result_type bs_res, x_res, c_res;

   assign plain_emit = ch != BACKSLASH;
   assign plain_mode = plain_emit ? MODE_TEXT : MODE_ESCAPE;
   assign bs_res     = mk_result(BACKSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
   assign x_res      = mk_result(LETTER_X, 1'b1, 1'b0, 1'b0, 1'b0);
   assign c_res      = mk_result(ch, 1'b1, 1'b0, 1'b0, 1'b0);

   always_comb begin
      burst   = '0;
      mode_in = mode_ff;
      held_in = held_ff;
      if (kind) begin
         mode_in = MODE_TEXT;
         held_in = 8'h00;
         unique case (mode_ff)
            MODE_TEXT: begin
               burst.ent[0] = mk_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
               burst.count  = 3'd1;
            end
            MODE_ESCAPE: begin
               burst.ent[0] = mk_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
               burst.count  = 3'd1;
            end
            MODE_HEX: begin
               burst.ent[0] = bs_res;
               burst.ent[1] = mk_result(LETTER_X, 1'b1, 1'b0, 1'b0, 1'b1);
               burst.count  = 3'd2;
            end
            default: begin
               burst.ent[0] = bs_res;
               burst.ent[1] = x_res;
               burst.ent[2] = mk_result(held_ff, 1'b1, 1'b0, 1'b0, 1'b1);
               burst.count  = 3'd3;
            end
         endcase
      end else begin
         unique case (mode_ff)
            MODE_TEXT: begin
               mode_in      = plain_mode;
               burst.ent[0] = c_res;
               burst.count  = plain_emit ? 3'd1 : 3'd0;
            end
            MODE_ESCAPE: begin
               if (ch == LETTER_X) begin
                  mode_in = MODE_HEX;
               end else begin
                  mode_in      = MODE_TEXT;
                  burst.count  = 3'd1;
                  burst.ent[0] = mk_result(escape_byte(ch), 1'b1, !is_escape(ch),
                                           1'b0, 1'b0);
               end
            end
            MODE_HEX: begin
               if (is_hex(ch)) begin
                  held_in = ch;
                  mode_in = MODE_HEX_ONE;
               end else begin
                  mode_in      = plain_mode;
                  burst.ent[0] = bs_res;
                  burst.ent[1] = x_res;
                  burst.ent[2] = c_res;
                  burst.count  = plain_emit ? 3'd3 : 3'd2;
               end
            end
            default: begin
               held_in = 8'h00;
               if (is_hex(ch)) begin
                  mode_in      = MODE_TEXT;
                  burst.ent[0] = mk_result({hex_nibble(held_ff), hex_nibble(ch)},
                                           1'b1, 1'b0, 1'b0, 1'b0);
                  burst.count  = 3'd1;
               end else begin
                  mode_in      = plain_mode;
                  burst.ent[0] = bs_res;
                  burst.ent[1] = x_res;
                  burst.ent[2] = mk_result(held_ff, 1'b1, 1'b0, 1'b0, 1'b0);
                  burst.ent[3] = c_res;
                  burst.count  = plain_emit ? 3'd4 : 3'd3;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         held_ff <= 8'h00;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

endmodule

// ===== rtl/core/sed_burst.sv =====
module sed_burst (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  sed_pkg::sed_burst_type  burst,
   input  logic                    pop,
   output logic                    can_take,
   output logic                    res_valid,
   output sed_pkg::sed_result_type res
);
   import sed_pkg::*;

   logic [2:0]     count_ff;
   logic [1:0]     idx_ff;
   sed_result_type ent_ff [MAX_RESULTS];

   assign res_valid = count_ff != 3'd0;
   assign res       = ent_ff[idx_ff];
   assign can_take  = (count_ff == 3'd0) || (count_ff == 3'd1 && pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         count_ff <= burst.count;
         idx_ff   <= 2'd0;
      end else if (res_valid && pop) begin
         count_ff <= count_ff - 3'd1;
         idx_ff   <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            ent_ff[i] <= burst.ent[i];
         end
      end
   end

endmodule

// ===== rtl/core/string_escape_decoder_unit.sv =====
// Channel   Direction  Ports                                          Handshake
// req       in         req_kind, req_ch                               req_valid/req_ready
// rsp       out        rsp_out_byte, rsp_has_byte, rsp_unknown_escape, rsp_valid/rsp_ready
//                      rsp_unterminated, rsp_last
//
// One item accepted per cycle while req_ready is high; the item decodes in the accept cycle into a burst
// register and its first result, if any, shows on rsp the next cycle.
// A burst of n results holds req_ready low until its last result is being popped (n up to 4, broken hex escape).
// Reset is synchronous, active high: text mode, no pending results.
// rsp stalls back up to req only through the burst register.
`include "string_escape_decoder_unit_defines.svh"

module string_escape_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_unknown_escape,
   output logic       rsp_unterminated,
   output logic       rsp_last
);
   import sed_pkg::*;

   logic           accept;
   sed_burst_type  burst;
   sed_result_type res;

   assign accept = req_valid && req_ready;

   sed_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .kind   (req_kind),
      .ch     (req_ch),
      .burst  (burst)
   );

   sed_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst     (burst),
      .pop       (rsp_ready),
      .can_take  (req_ready),
      .res_valid (rsp_valid),
      .res       (res)
   );

   assign rsp_out_byte       = res.out_byte;
   assign rsp_has_byte       = res.has_byte;
   assign rsp_unknown_escape = res.unknown_escape;
   assign rsp_unterminated   = res.unterminated;
   assign rsp_last           = res.last;

   `SED_ASSERT_NEXT(a_end_gives_result, clock, reset, accept && req_kind, rsp_valid, "end item produced no result")
   `SED_ASSERT_NOW(a_unterm_is_last, clock, reset, rsp_valid && rsp_unterminated, rsp_last && !rsp_has_byte, "unterminated result not final")
   `SED_ASSERT_NOW(a_no_byte_zero, clock, reset, rsp_valid && !rsp_has_byte, rsp_out_byte == 8'h00, "byte set without has_byte")
   `SED_ASSERT_NOW(a_unknown_has_byte, clock, reset, rsp_valid && rsp_unknown_escape, rsp_has_byte && !rsp_last, "unknown escape without byte")

endmodule

// ===== tb/sv/string_escape_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module string_escape_decoder_unit_tb;
   import sed_pkg::*;

   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_END   = 1'b1;
   localparam int   CYCLE_LIMIT = 200000;
   localparam int   HOLD_CYCLES = 120;
   localparam int   TAIL_CYCLES = 8;

   typedef struct {
      logic       kind;
      logic [7:0] ch;
   } char_item_type;

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_kind  = 1'b0;
   logic [7:0] req_ch    = 8'h00;
   logic       rsp_ready = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_unknown_escape;
   logic       rsp_unterminated;
   logic       rsp_last;

   char_item_type  pending_chars[$];
   sed_result_type decoded_q[$];
   logic [1:0]     dec_mode = MODE_TEXT;
   logic [7:0]     dec_held = 8'h00;
   logic           req_taken = 1'b0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   bit             hold_order = 1'b0;
   bit             hold_seen = 1'b0;
   int             hold_left = 0;
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             queued_count = 0;

   logic [7:0] esc_letters [12] = '{8'h30, 8'h61, 8'h62, 8'h65, 8'h66, 8'h6E,
                                    8'h72, 8'h74, 8'h76, BACKSLASH, 8'h27, 8'h22};

   string_escape_decoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_ch             (req_ch),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_unknown_escape (rsp_unknown_escape),
      .rsp_unterminated   (rsp_unterminated),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int hex_val(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   function automatic int esc_code(input logic [7:0] c);
      case (c)
         8'h30:     return 'h00;
         8'h61:     return 'h07;
         8'h62:     return 'h08;
         8'h65:     return int'(ESC_CHAR);
         8'h66:     return 'h0C;
         8'h6E:     return 'h0A;
         8'h72:     return 'h0D;
         8'h74:     return 'h09;
         8'h76:     return 'h0B;
         BACKSLASH: return int'(BACKSLASH);
         8'h27:     return 'h27;
         8'h22:     return 'h22;
         default:   return -1;
      endcase
   endfunction

   task automatic queue_result(input logic [7:0] b, input logic has, input logic unk,
                               input logic unt, input logic lst);
      sed_result_type r;
      r.out_byte       = b;
      r.has_byte       = has;
      r.unknown_escape = unk;
      r.unterminated   = unt;
      r.last           = lst;
      decoded_q.insert(decoded_q.size(), r);
   endtask

   task automatic text_char(input logic [7:0] c);
      if (c == BACKSLASH) begin
         dec_mode = MODE_ESCAPE;
      end else begin
         dec_mode = MODE_TEXT;
         queue_result(c, 1'b1, 1'b0, 1'b0, 1'b0);
      end
   endtask

   task automatic decode_item(input logic kind, input logic [7:0] c);
      int lo;
      int hi;
      if (kind == KIND_END) begin
         case (dec_mode)
            MODE_TEXT: begin
               queue_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            MODE_ESCAPE: begin
               queue_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
            end
            MODE_HEX: begin
               queue_result(BACKSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
               queue_result(LETTER_X, 1'b1, 1'b0, 1'b0, 1'b1);
            end
            default: begin
               queue_result(BACKSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
               queue_result(LETTER_X, 1'b1, 1'b0, 1'b0, 1'b0);
               queue_result(dec_held, 1'b1, 1'b0, 1'b0, 1'b1);
            end
         endcase
         dec_mode = MODE_TEXT;
         dec_held = 8'h00;
      end else begin
         case (dec_mode)
            MODE_TEXT: begin
               text_char(c);
            end
            MODE_ESCAPE: begin
               if (c == LETTER_X) begin
                  dec_mode = MODE_HEX;
               end else begin
                  dec_mode = MODE_TEXT;
                  lo = esc_code(c);
                  if (lo >= 0) begin
                     queue_result(lo[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
                  end else begin
                     queue_result(c, 1'b1, 1'b1, 1'b0, 1'b0);
                  end
               end
            end
            MODE_HEX: begin
               if (hex_val(c) >= 0) begin
                  dec_held = c;
                  dec_mode = MODE_HEX_ONE;
               end else begin
                  queue_result(BACKSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
                  queue_result(LETTER_X, 1'b1, 1'b0, 1'b0, 1'b0);
                  text_char(c);
               end
            end
            default: begin
               lo = hex_val(c);
               if (lo >= 0) begin
                  hi = hex_val(dec_held);
                  if (hi < 0) hi = 0;
                  lo = hi * 16 + lo;
                  queue_result(lo[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
                  dec_mode = MODE_TEXT;
               end else begin
                  queue_result(BACKSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
                  queue_result(LETTER_X, 1'b1, 1'b0, 1'b0, 1'b0);
                  queue_result(dec_held, 1'b1, 1'b0, 1'b0, 1'b0);
                  text_char(c);
               end
               dec_held = 8'h00;
            end
         endcase
      end
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("ERROR at %0t: %s got 0x%0h, want 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic push_item(input logic kind, input logic [7:0] c);
      char_item_type it;
      it.kind = kind;
      it.ch   = c;
      pending_chars.insert(pending_chars.size(), it);
      queued_count++;
   endtask

   task automatic push_end();
      push_item(KIND_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_item(KIND_CHAR, s[i]);
   endtask

   function automatic logic [7:0] rand_hex_digit();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) return 8'(8'h30 + v);
      if (v < 16) return 8'(8'h61 + v - 10);
      return 8'(8'h41 + v - 16);
   endfunction

   task automatic add_random_text(input int n);
      int start;
      int pick;
      logic [7:0] c;
      start = queued_count;
      while (queued_count - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            c = 8'($urandom_range(0, 255));
            if (c == BACKSLASH) c = 8'h41;
            push_item(KIND_CHAR, c);
         end else if (pick < 45) begin
            push_item(KIND_CHAR, BACKSLASH);
            push_item(KIND_CHAR, esc_letters[$urandom_range(0, 11)]);
         end else if (pick < 58) begin
            push_item(KIND_CHAR, BACKSLASH);
            push_item(KIND_CHAR, LETTER_X);
            push_item(KIND_CHAR, rand_hex_digit());
            push_item(KIND_CHAR, rand_hex_digit());
         end else if (pick < 66) begin
            c = 8'($urandom_range(0, 255));
            if (c == LETTER_X) c = 8'h71;
            push_item(KIND_CHAR, BACKSLASH);
            push_item(KIND_CHAR, c);
         end else if (pick < 76) begin
            push_item(KIND_CHAR, BACKSLASH);
            push_item(KIND_CHAR, LETTER_X);
            if ($urandom_range(0, 1)) push_item(KIND_CHAR, rand_hex_digit());
            push_item(KIND_CHAR, 8'($urandom_range(0, 255)));
         end else if (pick < 86) begin
            push_end();
         end else if (pick < 92) begin
            push_item(KIND_CHAR, BACKSLASH);
            if ($urandom_range(0, 2) != 0) begin
               push_item(KIND_CHAR, LETTER_X);
               if ($urandom_range(0, 1)) push_item(KIND_CHAR, rand_hex_digit());
            end
            push_end();
         end else begin
            repeat ($urandom_range(1, 4)) begin
               push_item(($urandom_range(0, 4) == 0) ? KIND_END : KIND_CHAR,
                         8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic wait_drain();
      @(negedge clock);
      #1;
      while (pending_chars.size() != 0 || req_valid || decoded_q.size() != 0) begin
         @(negedge clock);
         #1;
      end
   endtask

   always @(negedge clock) begin
      char_item_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_chars.pop_front();
            req_valid <= 1'b1;
            req_kind  <= nxt.kind;
            req_ch    <= nxt.ch;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_order && !hold_seen) begin
         hold_seen = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      sed_result_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) decode_item(req_kind, req_ch);
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("unexpected item, out_byte", rsp_out_byte, 0);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, want.out_byte);
               if (rsp_has_byte !== want.has_byte)
                  report_mismatch("has_byte", rsp_has_byte, want.has_byte);
               if (rsp_unknown_escape !== want.unknown_escape)
                  report_mismatch("unknown_escape", rsp_unknown_escape, want.unknown_escape);
               if (rsp_unterminated !== want.unterminated)
                  report_mismatch("unterminated", rsp_unterminated, want.unterminated);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 33;
      recv_idle_pct = 50;
      push_item(KIND_CHAR, 8'h00);
      push_item(KIND_CHAR, 8'hFF);
      push_text("\\n\\e\\xFa\\q");
      push_end();
      push_text("\\xg\\x3z\\x3\\");
      push_end();
      push_text("\\x");
      push_end();
      push_text("\\x7");
      push_end();
      add_random_text(120);
      wait_drain();

      // receiver stalls long enough to back up the burst register
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_order = 1'b1;
      repeat (6) push_text("\\x5zab\\x\\");
      add_random_text(20);
      wait_drain();

      send_idle_pct = 50;
      recv_idle_pct = 33;
      add_random_text(120);
      wait_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_text(120);
      wait_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
